// ===== rtl/b3h_pkg.sv =====
package b3h_pkg;

  localparam int unsigned StackDepth = 54;
  localparam int unsigned StackAw    = 6;

  localparam logic [31:0] FlagStart  = 32'd1;
  localparam logic [31:0] FlagEnd    = 32'd2;
  localparam logic [31:0] FlagParent = 32'd4;
  localparam logic [31:0] FlagRoot   = 32'd8;

  typedef logic [7:0][31:0]  cv_t;
  typedef logic [15:0][31:0] blk_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0: w = 32'h6a09e667;
      3'd1: w = 32'hbb67ae85;
      3'd2: w = 32'h3c6ef372;
      3'd3: w = 32'ha54ff53a;
      3'd4: w = 32'h510e527f;
      3'd5: w = 32'h9b05688c;
      3'd6: w = 32'h1f83d9ab;
      default: w = 32'h5be0cd19;
    endcase
    return w;
  endfunction

  function automatic cv_t iv_cv();
    cv_t c;
    for (int i = 0; i < 8; i++) c[i] = iv_word(3'(i));
    return c;
  endfunction

  function automatic logic [3:0] perm(input logic [3:0] i);
    logic [3:0] p;
    unique case (i)
      4'd0: p = 4'd2;   4'd1: p = 4'd6;   4'd2: p = 4'd3;   4'd3: p = 4'd10;
      4'd4: p = 4'd7;   4'd5: p = 4'd0;   4'd6: p = 4'd4;   4'd7: p = 4'd13;
      4'd8: p = 4'd1;   4'd9: p = 4'd11;  4'd10: p = 4'd12; 4'd11: p = 4'd5;
      4'd12: p = 4'd9;  4'd13: p = 4'd14; 4'd14: p = 4'd15; default: p = 4'd8;
    endcase
    return p;
  endfunction

  // Controller states.
  typedef enum logic [3:0] {
    StIdle,
    StCompBlk,   // non-final block, chunk continues
    StCompEnd,   // chunk-end block
    StMerge,     // parent merge after chunk end
    StPush,
    StFinal,
    StFold,
    StOut
  } state_e;

  typedef enum logic [1:0] {
    CmpChunk,
    CmpParent
  } cmp_src_e;

  // Controller to datapath.
  typedef struct packed {
    logic       cmp_start;
    cmp_src_e   cmp_src;
    logic [6:0] cmp_len;
    logic [3:0] cmp_flags;
    logic       absorb_item;
    logic       absorb_byte;   // append the pending overflow bytes then done
    logic       blk_done;      // chain result into cv, clear block
    logic       chunk_done;    // reset chunk state, counter++
    logic       pop;
    logic       push;
    logic       take_stack_rd; // registered stack read is valid
    logic       load_out;
    logic       clear_all;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       cmp_busy;
    logic       cmp_done;
    logic [6:0] block_fill;
    logic [3:0] blocks_done;
    logic       ctr_low_bit;  // parity of current merge total
    logic [StackAw-1:0] stack_count;
  } dp_sts_t;

endpackage

// ===== rtl/blake3_hash_engine_core.sv =====
// BLAKE3-256 hash engine, unkeyed mode.
// Input channel s_axis: one transfer carries up to eight message bytes
// (first byte in tdata[7:0]), the valid byte count in tuser and tlast on
// the final transfer. An empty message is one tlast transfer with count 0.
// Output channel m_axis: four transfers of 64 digest bits, tuser carrying
// the word index; tlast marks the fourth word.
// Every compression, chunk block or parent merge, runs on a single shared
// round unit (one round per cycle).
// After tlast the final block and each stacked subtree are compressed in
// turn, then the digest words stream out.
// Reset clears the controller and chunk state; the chaining-value stack
// memory is not cleared, since entries are only read after being written.
// A stall on m_axis holds the current digest word; no new input is taken
// until all four words are transferred.
module blake3_hash_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // data_bytes[63:0]
  input  logic [3:0]  s_axis_tuser,   // byte_count[3:0]
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word[63:0]
  output logic [1:0]  m_axis_tuser,   // word_index[1:0]
  output logic        m_axis_tlast    // last_word
);

  b3h_pkg::dp_cmd_t cmd;
  b3h_pkg::dp_sts_t sts;
  logic [1:0] wsel;

  b3h_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_count_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .word_sel_o  (wsel),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  b3h_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .data_i     (s_axis_tdata),
    .count_i    (s_axis_tuser),
    .word_o     (m_axis_tdata),
    .word_sel_i (wsel)
  );

  assign m_axis_tuser = wsel;
  assign m_axis_tlast = (wsel == 2'd3);

endmodule

// ===== rtl/b3h_compress.sv =====
// One round per cycle over seven rounds.
module b3h_compress (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  b3h_pkg::cv_t        cv_i,
  input  b3h_pkg::blk_t       msg_i,
  input  logic [63:0]         ctr_i,
  input  logic [6:0]          len_i,
  input  logic [3:0]          flags_i,
  output logic                busy_o,
  output logic                done_o,
  output b3h_pkg::cv_t        out_o
);

  logic [15:0][31:0] v_q, v_d;
  b3h_pkg::blk_t     m_q, m_d;
  logic [2:0]        rnd_q, rnd_d;
  logic              busy_q, busy_d, done_q, done_d;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [15:0][31:0] g(input logic [15:0][31:0] v,
      input int a, input int b, input int c, input int d,
      input logic [31:0] mx, input logic [31:0] my);
    logic [15:0][31:0] w;
    w = v;
    w[a] = w[a] + w[b] + mx;
    w[d] = rotr(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d];
    w[b] = rotr(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b] + my;
    w[d] = rotr(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d];
    w[b] = rotr(w[b] ^ w[c], 7);
    return w;
  endfunction

  logic [15:0][31:0] rv;
  always_comb begin
    rv = v_q;
    rv = g(rv, 0, 4, 8, 12, m_q[0], m_q[1]);
    rv = g(rv, 1, 5, 9, 13, m_q[2], m_q[3]);
    rv = g(rv, 2, 6, 10, 14, m_q[4], m_q[5]);
    rv = g(rv, 3, 7, 11, 15, m_q[6], m_q[7]);
    rv = g(rv, 0, 5, 10, 15, m_q[8], m_q[9]);
    rv = g(rv, 1, 6, 11, 12, m_q[10], m_q[11]);
    rv = g(rv, 2, 7, 8, 13, m_q[12], m_q[13]);
    rv = g(rv, 3, 4, 9, 14, m_q[14], m_q[15]);
  end

  always_comb begin
    v_d = v_q; m_d = m_q; rnd_d = rnd_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      for (int i = 0; i < 8; i++) v_d[i] = cv_i[i];
      for (int i = 0; i < 4; i++) v_d[8+i] = b3h_pkg::iv_word(3'(i));
      v_d[12] = ctr_i[31:0];
      v_d[13] = ctr_i[63:32];
      v_d[14] = {25'd0, len_i};
      v_d[15] = {28'd0, flags_i};
      m_d = msg_i;
      rnd_d = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      v_d = rv;
      for (int i = 0; i < 16; i++) m_d[i] = m_q[b3h_pkg::perm(4'(i))];
      rnd_d = rnd_q + 3'd1;
      if (rnd_q == 3'd6) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    m_q <= m_d;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) out_o[i] = v_q[i] ^ v_q[i+8];
  end
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== rtl/b3h_datapath.sv =====
module b3h_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b3h_pkg::dp_cmd_t  cmd_i,
  output b3h_pkg::dp_sts_t  sts_o,
  input  logic [63:0]       data_i,
  input  logic [3:0]        count_i,
  output logic [63:0]       word_o,
  input  logic [1:0]        word_sel_i
);

  b3h_pkg::cv_t  cv_q, cv_d, res_q, res_d;
  b3h_pkg::blk_t blk_q, blk_d;
  logic [6:0]    fill_q, fill_d;
  logic [3:0]    bdone_q, bdone_d;
  logic [63:0]   ctr_q, ctr_d, tot_q, tot_d;
  logic [b3h_pkg::StackAw-1:0] sc_q, sc_d;
  logic [3:0]    cnt;
  logic [3:0]    take;
  logic [3:0]    rem_q, rem_d;
  logic [63:0]   rdat_q, rdat_d;

  // Stack memory: one 256-bit row per entry.
  logic [255:0] stk_mem [b3h_pkg::StackDepth];
  logic [255:0] stk_rd_q;
  b3h_pkg::cv_t left_q;
  logic [b3h_pkg::StackAw-1:0] rd_addr;

  b3h_pkg::cv_t cmp_cv;
  b3h_pkg::blk_t cmp_msg;
  b3h_pkg::cv_t cmp_out;
  logic cmp_busy, cmp_done;

  assign cnt = (count_i > 4'd8) ? 4'd8 : count_i;

  always_comb begin
    if (cmd_i.cmp_src == b3h_pkg::CmpParent) begin
      cmp_cv = b3h_pkg::iv_cv();
      for (int i = 0; i < 8; i++) begin
        cmp_msg[i]   = left_q[i];
        cmp_msg[8+i] = res_q[i];
      end
    end else begin
      cmp_cv  = cv_q;
      cmp_msg = blk_q;
    end
  end

  b3h_compress u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cmp_start),
    .cv_i    (cmp_cv),
    .msg_i   (cmp_msg),
    .ctr_i   ((cmd_i.cmp_src == b3h_pkg::CmpParent) ? 64'd0 : ctr_q),
    .len_i   (cmd_i.cmp_len),
    .flags_i (cmd_i.cmp_flags),
    .busy_o  (cmp_busy),
    .done_o  (cmp_done),
    .out_o   (cmp_out)
  );

  // Bytes of an item that fit before the block is full; rest held in rdat/rem.
  always_comb begin
    logic [6:0] room;
    room = 7'd64 - fill_q;
    take = (room < {3'd0, cnt}) ? room[3:0] : cnt;
  end

  always_comb begin
    logic [63:0] src;
    logic [3:0]  n;
    logic [6:0]  f;
    cv_d = cv_q; res_d = res_q; blk_d = blk_q; fill_d = fill_q; bdone_d = bdone_q;
    ctr_d = ctr_q; tot_d = tot_q; sc_d = sc_q; rem_d = rem_q; rdat_d = rdat_q;
    src = 64'd0; n = 4'd0;
    if (cmd_i.absorb_item) begin
      src = data_i; n = take;
      rem_d  = cnt - take;
      rdat_d = data_i >> {take, 3'b000};
    end else if (cmd_i.absorb_byte) begin
      src = rdat_q; n = rem_q;
      rem_d = 4'd0;
    end
    f = fill_q;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        blk_d[f[5:2]][{f[1:0], 3'b000} +: 8] = src[8*i +: 8];
        f = f + 7'd1;
      end
    end
    fill_d = f;
    if (cmd_i.load_out) res_d = cmp_out;
    if (cmd_i.blk_done) begin
      cv_d = cmp_out; blk_d = '0; fill_d = 7'd0; bdone_d = bdone_q + 4'd1;
    end
    if (cmd_i.chunk_done) begin
      cv_d = b3h_pkg::iv_cv(); blk_d = '0; fill_d = 7'd0; bdone_d = 4'd0;
      ctr_d = ctr_q + 64'd1;
      tot_d = ctr_q + 64'd1;
    end
    if (cmd_i.pop) begin
      sc_d = sc_q - 1'b1;
      tot_d = tot_q >> 1;
    end
    if (cmd_i.push && sc_q < b3h_pkg::StackAw'(b3h_pkg::StackDepth)) sc_d = sc_q + 1'b1;
    if (cmd_i.clear_all) begin
      cv_d = b3h_pkg::iv_cv(); blk_d = '0; fill_d = 7'd0; bdone_d = 4'd0;
      ctr_d = 64'd0; sc_d = '0; rem_d = 4'd0;
    end
  end

  assign rd_addr = sc_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && sc_q < b3h_pkg::StackAw'(b3h_pkg::StackDepth))
      stk_mem[sc_q] <= res_q;
    stk_rd_q <= stk_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; tot_q <= tot_d; rdat_q <= rdat_d;
    if (cmd_i.take_stack_rd) left_q <= stk_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= b3h_pkg::iv_cv(); blk_q <= '0;
      fill_q <= 7'd0; bdone_q <= 4'd0; ctr_q <= 64'd0; sc_q <= '0; rem_q <= 4'd0;
    end else begin
      cv_q <= cv_d; blk_q <= blk_d;
      fill_q <= fill_d; bdone_q <= bdone_d; ctr_q <= ctr_d; sc_q <= sc_d;
      rem_q <= rem_d;
    end
  end

  assign word_o = {res_q[{word_sel_i, 1'b1}], res_q[{word_sel_i, 1'b0}]};

  assign sts_o.cmp_busy    = cmp_busy;
  assign sts_o.cmp_done    = cmp_done;
  assign sts_o.block_fill  = fill_q;
  assign sts_o.blocks_done = bdone_q;
  assign sts_o.ctr_low_bit = tot_q[0] | (rem_q != 4'd0 ? 1'b0 : 1'b0);
  assign sts_o.stack_count = sc_q;

endmodule

// ===== rtl/b3h_ctrl.sv =====
module b3h_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        in_count_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        word_sel_o,
  output b3h_pkg::dp_cmd_t  cmd_o,
  input  b3h_pkg::dp_sts_t  sts_i
);

  b3h_pkg::state_e st_q, st_d;
  logic [1:0] sub_q, sub_d;     // step within merge/fold: 0 read, 1 latch, 2 compress
  logic [1:0] wsel_q, wsel_d;
  logic       last_q, last_d;   // last item pending behind overflow
  logic       pend_q, pend_d;   // overflow bytes wait in datapath
  logic [3:0] cnt;

  assign cnt = (in_count_i > 4'd8) ? 4'd8 : in_count_i;

  always_comb begin
    logic [3:0] fl;
    st_d = st_q; sub_d = sub_q; wsel_d = wsel_q; last_d = last_q; pend_d = pend_q;
    cmd_o = '0;
    cmd_o.cmp_src = b3h_pkg::CmpChunk;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    fl = (sts_i.blocks_done == 4'd0) ? b3h_pkg::FlagStart[3:0] : 4'd0;
    unique case (st_q)
      b3h_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.absorb_item = 1'b1;
          // Block already full and more bytes coming: compress it first.
          if (sts_i.block_fill == 7'd64 && cnt != 4'd0) begin
            cmd_o.absorb_item = 1'b0;
            in_ready_o = 1'b0;
            cmd_o.cmp_start = 1'b1;
            cmd_o.cmp_len = 7'd64;
            pend_d = 1'b0;
            if (sts_i.blocks_done >= 4'd15) begin
              cmd_o.cmp_flags = fl | b3h_pkg::FlagEnd[3:0];
              st_d = b3h_pkg::StCompEnd;
            end else begin
              cmd_o.cmp_flags = fl;
              st_d = b3h_pkg::StCompBlk;
            end
          end else begin
            pend_d = ({3'd0, cnt} + sts_i.block_fill > 7'd64);
            last_d = in_last_i;
            if (pend_d) begin
              st_d = b3h_pkg::StCompBlk;
              cmd_o.cmp_start = 1'b1;
              cmd_o.cmp_len = 7'd64;
              cmd_o.cmp_flags = fl;
              // overflow means the next bytes exist, fill exactly reaches 64
              // after this transfer; compression uses updated block next cycle
              cmd_o.cmp_start = 1'b0;
              st_d = b3h_pkg::StPush;
              sub_d = 2'd3;
            end else if (in_last_i) begin
              st_d = b3h_pkg::StFinal;
              sub_d = 2'd0;
            end
          end
        end
      end
      b3h_pkg::StPush: begin
        if (sub_q == 2'd3) begin
          // Full block with spill bytes held: flush it.
          cmd_o.cmp_start = 1'b1;
          cmd_o.cmp_len = 7'd64;
          if (sts_i.blocks_done >= 4'd15) begin
            cmd_o.cmp_flags = fl | b3h_pkg::FlagEnd[3:0];
            st_d = b3h_pkg::StCompEnd;
          end else begin
            cmd_o.cmp_flags = fl;
            st_d = b3h_pkg::StCompBlk;
          end
        end else begin
          // Chunk state was already advanced at the chunk-end block.
          cmd_o.push = 1'b1;
          st_d = b3h_pkg::StCompBlk;
          sub_d = 2'd2;
        end
      end
      b3h_pkg::StCompBlk: begin
        if (sub_q == 2'd2) begin
          sub_d = 2'd0;
          if (pend_q) begin
            cmd_o.absorb_byte = 1'b1;
            pend_d = 1'b0;
          end
          st_d = last_q && pend_q ? b3h_pkg::StFinal : b3h_pkg::StIdle;
          if (!pend_q) last_d = 1'b0;
          if (!pend_q && last_q) st_d = b3h_pkg::StFinal;
        end else if (sts_i.cmp_done) begin
          cmd_o.blk_done = 1'b1;
          sub_d = 2'd2;
        end
      end
      b3h_pkg::StCompEnd: begin
        if (sts_i.cmp_done) begin
          cmd_o.load_out = 1'b1;
          cmd_o.chunk_done = 1'b1;
          st_d = b3h_pkg::StMerge;
          sub_d = 2'd0;
        end
      end
      b3h_pkg::StMerge: begin
        unique case (sub_q)
          2'd0: begin
            if (!sts_i.ctr_low_bit && sts_i.stack_count != '0) sub_d = 2'd1;
            else begin
              st_d = b3h_pkg::StPush;
              sub_d = 2'd1;
            end
          end
          2'd1: begin
            cmd_o.take_stack_rd = 1'b1;
            cmd_o.pop = 1'b1;
            sub_d = 2'd2;
          end
          2'd2: begin
            cmd_o.cmp_src = b3h_pkg::CmpParent;
            cmd_o.cmp_start = 1'b1;
            cmd_o.cmp_len = 7'd64;
            cmd_o.cmp_flags = b3h_pkg::FlagParent[3:0];
            sub_d = 2'd3;
          end
          default: begin
            cmd_o.cmp_src = b3h_pkg::CmpParent;
            if (sts_i.cmp_done) begin
              cmd_o.load_out = 1'b1;
              sub_d = 2'd0;
            end
          end
        endcase
      end
      b3h_pkg::StFinal: begin
        unique case (sub_q)
          2'd0: begin
            cmd_o.cmp_start = 1'b1;
            cmd_o.cmp_len = sts_i.block_fill;
            cmd_o.cmp_flags = fl | b3h_pkg::FlagEnd[3:0] |
              ((sts_i.stack_count == '0) ? b3h_pkg::FlagRoot[3:0] : 4'd0);
            sub_d = 2'd1;
          end
          default: begin
            if (sts_i.cmp_done) begin
              cmd_o.load_out = 1'b1;
              st_d = b3h_pkg::StFold;
              sub_d = 2'd0;
            end
          end
        endcase
      end
      b3h_pkg::StFold: begin
        unique case (sub_q)
          2'd0: begin
            if (sts_i.stack_count == '0) begin
              st_d = b3h_pkg::StOut;
              wsel_d = 2'd0;
            end else sub_d = 2'd1;
          end
          2'd1: begin
            cmd_o.take_stack_rd = 1'b1;
            cmd_o.pop = 1'b1;
            sub_d = 2'd2;
          end
          2'd2: begin
            cmd_o.cmp_src = b3h_pkg::CmpParent;
            cmd_o.cmp_start = 1'b1;
            cmd_o.cmp_len = 7'd64;
            cmd_o.cmp_flags = b3h_pkg::FlagParent[3:0] |
              ((sts_i.stack_count == '0) ? b3h_pkg::FlagRoot[3:0] : 4'd0);
            sub_d = 2'd3;
          end
          default: begin
            cmd_o.cmp_src = b3h_pkg::CmpParent;
            if (sts_i.cmp_done) begin
              cmd_o.load_out = 1'b1;
              sub_d = 2'd0;
            end
          end
        endcase
      end
      b3h_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          wsel_d = wsel_q + 2'd1;
          if (wsel_q == 2'd3) begin
            cmd_o.clear_all = 1'b1;
            last_d = 1'b0;
            pend_d = 1'b0;
            st_d = b3h_pkg::StIdle;
          end
        end
      end
      default: st_d = b3h_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= b3h_pkg::StIdle;
      sub_q <= 2'd0; wsel_q <= 2'd0; last_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      st_q <= st_d; sub_q <= sub_d; wsel_q <= wsel_d; last_q <= last_d; pend_q <= pend_d;
    end
  end

  assign word_sel_o = wsel_q;

  ap_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> st_q == b3h_pkg::StOut) else $error("out valid outside output");
  ap_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts_i.cmp_busy) else $error("input taken while compressing");
  ap_wrap_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == b3h_pkg::StOut && out_ready_i && wsel_q == 2'd3) |=>
    st_q == b3h_pkg::StIdle) else $error("no return to idle");

endmodule

// ===== tb/sv/tb_blake3_hash_engine_core.sv =====
module tb_blake3_hash_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // data_bytes[63:0]
  logic [3:0]  s_axis_tuser;   // byte_count[3:0]
  logic        s_axis_tlast;   // last_item
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // digest_word[63:0]
  logic [1:0]  m_axis_tuser;   // word_index[1:0]
  logic        m_axis_tlast;   // last_word

  blake3_hash_engine_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_out_t;

  // Directed row: the digest is typed in only for rows with a known answer.
  typedef struct {
    msg_item_t   item;
    bit          has_known;
    logic [63:0] known_word0;
  } stim_row_t;

  localparam int unsigned NumRows = 14;
  stim_row_t stim_rows [NumRows];

  // Hashing state of the predictor.
  b3h_pkg::cv_t  hs_cv;
  b3h_pkg::blk_t hs_blk;
  int unsigned   hs_fill;
  int unsigned   hs_blocks;
  logic [63:0]   hs_chunk;
  b3h_pkg::cv_t  hs_stack [b3h_pkg::StackDepth];
  int unsigned   hs_depth;

  digest_out_t digest_q [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          stall_rx;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic b3h_pkg::cv_t compress_block(input b3h_pkg::cv_t cv,
      input b3h_pkg::blk_t m_in, input logic [63:0] ctr, input int unsigned len,
      input logic [31:0] flags);
    localparam int Sched [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};
    localparam int Qa [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
    localparam int Qb [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
    localparam int Qc [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
    localparam int Qd [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
    logic [31:0] v [16];
    b3h_pkg::blk_t m, t;
    b3h_pkg::cv_t  res;
    int a, b, c, d;
    m = m_in;
    for (int i = 0; i < 8; i++) v[i] = cv[i];
    v[8]  = 32'h6a09e667; v[9]  = 32'hbb67ae85;
    v[10] = 32'h3c6ef372; v[11] = 32'ha54ff53a;
    v[12] = ctr[31:0]; v[13] = ctr[63:32];
    v[14] = len; v[15] = flags;
    for (int r = 0; r < 7; r++) begin
      for (int q = 0; q < 8; q++) begin
        a = Qa[q]; b = Qb[q]; c = Qc[q]; d = Qd[q];
        v[a] = v[a] + v[b] + m[2*q];
        v[d] = rotr(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 12);
        v[a] = v[a] + v[b] + m[2*q+1];
        v[d] = rotr(v[d] ^ v[a], 8);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 7);
      end
      for (int i = 0; i < 16; i++) t[i] = m[Sched[i]];
      m = t;
    end
    for (int i = 0; i < 8; i++) res[i] = v[i] ^ v[i+8];
    return res;
  endfunction

  function automatic b3h_pkg::cv_t merge_parent(input b3h_pkg::cv_t l,
      input b3h_pkg::cv_t r, input logic [31:0] flags);
    b3h_pkg::blk_t blk;
    for (int i = 0; i < 8; i++) begin
      blk[i] = l[i];
      blk[i+8] = r[i];
    end
    return compress_block(b3h_pkg::iv_cv(), blk, 64'd0, 64,
                          b3h_pkg::FlagParent | flags);
  endfunction

  task automatic hash_restart();
    hs_cv = b3h_pkg::iv_cv();
    hs_blk = '0;
    hs_fill = 0;
    hs_blocks = 0;
    hs_chunk = '0;
    hs_depth = 0;
  endtask

  // A full block is only compressed once a further byte proves it non-final.
  task automatic hash_flush();
    b3h_pkg::cv_t cv;
    logic [31:0]  st;
    logic [63:0]  total;
    st = (hs_blocks == 0) ? b3h_pkg::FlagStart : '0;
    if (hs_blocks >= 15) begin
      cv = compress_block(hs_cv, hs_blk, hs_chunk, 64, st | b3h_pkg::FlagEnd);
      total = hs_chunk + 1;
      while (total[0] == 1'b0 && hs_depth > 0) begin
        hs_depth--;
        cv = merge_parent(hs_stack[hs_depth], cv, '0);
        total = total >> 1;
      end
      if (hs_depth < b3h_pkg::StackDepth) begin
        hs_stack[hs_depth] = cv;
        hs_depth++;
      end
      hs_chunk++;
      hs_cv = b3h_pkg::iv_cv();
      hs_blocks = 0;
    end else begin
      hs_cv = compress_block(hs_cv, hs_blk, hs_chunk, 64, st);
      hs_blocks++;
    end
    hs_blk = '0;
    hs_fill = 0;
  endtask

  // Absorb one accepted transfer; on the last one queue the four digest words.
  task automatic hash_absorb(input msg_item_t it);
    int unsigned  n;
    logic [31:0]  flags;
    b3h_pkg::cv_t cv;
    digest_out_t  d;
    n = (it.count > 8) ? 8 : it.count;
    for (int i = 0; i < n; i++) begin
      if (hs_fill >= 64) hash_flush();
      hs_blk[hs_fill / 4][8*(hs_fill % 4) +: 8] = it.data[8*i +: 8];
      hs_fill++;
    end
    if (!it.last) return;
    flags = b3h_pkg::FlagEnd | ((hs_depth == 0) ? b3h_pkg::FlagRoot : '0) |
            ((hs_blocks == 0) ? b3h_pkg::FlagStart : '0);
    cv = compress_block(hs_cv, hs_blk, hs_chunk, hs_fill, flags);
    while (hs_depth > 0) begin
      hs_depth--;
      cv = merge_parent(hs_stack[hs_depth], cv,
                        (hs_depth == 0) ? b3h_pkg::FlagRoot : '0);
    end
    for (int k = 0; k < 4; k++) begin
      d.word = {cv[2*k+1], cv[2*k]};
      d.index = 2'(k);
      d.last = (k == 3);
      digest_q.push_back(d);
    end
    hash_restart();
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  // Valid drops only when a real gap follows, so it never gets two updates
  // in one time step.
  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Send one transfer and hold it until the handshake completes.
  task automatic send_item(input msg_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.data;
    s_axis_tuser  <= it.count;
    s_axis_tlast  <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    hash_absorb(it);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Random message: mostly small, a few spanning several chunks.
  task automatic send_message(input int unsigned nbytes);
    msg_item_t it;
    int unsigned left;
    left = nbytes;
    do begin
      it.data = {$urandom, $urandom};
      it.count = (left >= 8) ? 4'd8 : 4'(left);
      // occasional short transfer mid-message, and counts above eight
      if (left > 8 && $urandom_range(0, 30) == 0) it.count = 4'($urandom_range(0, 7));
      if (left >= 8 && $urandom_range(0, 30) == 0) it.count = 4'($urandom_range(9, 15));
      left -= (it.count > 8) ? 8 : it.count;
      it.last = (left == 0);
      send_item(it);
      if (!it.last) idle_gap();
    end while (left != 0);
  endtask

  // Output side: random stalls, checked against the oldest expected word.
  always @(posedge clk_i) begin
    digest_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest word", m_axis_tdata, '0);
        end else begin
          want = digest_q.pop_front();
          if (m_axis_tdata !== want.word)
            report_mismatch("digest word", m_axis_tdata, want.word);
          if (m_axis_tuser !== want.index)
            report_mismatch("word index", 64'(m_axis_tuser), 64'(want.index));
          if (m_axis_tlast !== want.last)
            report_mismatch("last word", 64'(m_axis_tlast), 64'(want.last));
        end
      end
      if ($urandom_range(0, 15) == 0) stall_rx <= ~stall_rx;
      m_axis_tready <= stall_rx ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned n_items;
    // empty-message digest, word 0: af1349b9 f5f9a1a6 little-endian
    stim_rows[0]  = '{'{64'h0, 4'd0, 1'b1}, 1'b1, 64'ha6a1f9f5_b94913af};
    stim_rows[1]  = '{'{64'hffffffff_ffffffff, 4'd8, 1'b1}, 1'b0, '0};
    stim_rows[2]  = '{'{64'h0, 4'd8, 1'b1}, 1'b0, '0};
    stim_rows[3]  = '{'{64'h00000000_00000061, 4'd1, 1'b1}, 1'b0, '0};
    stim_rows[4]  = '{'{64'hffffffff_ffffff61, 4'd1, 1'b1}, 1'b0, '0};
    stim_rows[5]  = '{'{64'h01234567_89abcdef, 4'd15, 1'b1}, 1'b0, '0};
    stim_rows[6]  = '{'{64'h01234567_89abcdef, 4'd9, 1'b1}, 1'b0, '0};
    stim_rows[7]  = '{'{64'h55aa55aa_55aa55aa, 4'd3, 1'b0}, 1'b0, '0};
    stim_rows[8]  = '{'{64'haa55aa55_aa55aa55, 4'd7, 1'b0}, 1'b0, '0};
    stim_rows[9]  = '{'{64'hdeadbeef_cafef00d, 4'd0, 1'b0}, 1'b0, '0};
    stim_rows[10] = '{'{64'h80808080_80808080, 4'd6, 1'b1}, 1'b0, '0};
    stim_rows[11] = '{'{64'h7f7f7f7f_7f7f7f7f, 4'd8, 1'b0}, 1'b0, '0};
    stim_rows[12] = '{'{64'hffffffff_ffffffff, 4'd4, 1'b0}, 1'b0, '0};
    stim_rows[13] = '{'{64'h0, 4'd0, 1'b1}, 1'b0, '0};

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    stall_rx = 1'b0;
    hash_restart();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      send_item(stim_rows[r].item);
      if (stim_rows[r].has_known && digest_q.size() == 4 &&
          digest_q[0].word !== stim_rows[r].known_word0)
        report_mismatch("model of empty digest", digest_q[0].word,
                        stim_rows[r].known_word0);
      idle_gap();
    end

    // Exactly 64, 65 and 1024 bytes: block and chunk boundaries; 2049 bytes
    // spans three chunks with two parent merges.
    send_message(64);
    send_message(65);
    send_message(1024);
    send_message(2049);
    // sender holds off until every digest word is out
    wait_drained();
    repeat (5) @(posedge clk_i);

    n_items = 0;
    while (n_items < 50) begin
      int unsigned len;
      case ($urandom_range(0, 9))
        0, 1, 2: len = $urandom_range(0, 8);
        3: len = 64 * $urandom_range(1, 2);
        default: len = $urandom_range(1, 120);
      endcase
      send_message(len);
      n_items += (len == 0) ? 1 : (len + 7) / 8;
      idle_gap();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
